### rtl/l2_ball_projection_4vec_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the ball projection block.
// ----------------------------------------------------------------------------
`ifndef L2_BALL_PROJECTION_4VEC_TOP_ASSERT_SVH
`define L2_BALL_PROJECTION_4VEC_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define L2BP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication, sampled on clk, off during reset
`define L2BP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/l2bp_pkg.sv
// ----------------------------------------------------------------------------
// l2bp_pkg
// Widths, depths and types of the ball projection pipeline.
// ----------------------------------------------------------------------------
package l2bp_pkg;

    localparam int COMP_WIDTH   = 16;
    localparam int FRAC_BITS    = 12;
    localparam int NUM_COMPS    = 4;
    localparam int RADIUS_WIDTH = 16;
    localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = RADIUS_WIDTH'(1) << FRAC_BITS;

    localparam int SQ_WIDTH    = 2 * COMP_WIDTH;
    localparam int NORM_WIDTH  = SQ_WIDTH + 1;
    localparam int R2_WIDTH    = 2 * RADIUS_WIDTH;
    localparam int ROOT_STEPS  = (NORM_WIDTH + 1) / 2;
    localparam int ROOT_WIDTH  = ROOT_STEPS;
    localparam int SQRT_WIDTH  = NORM_WIDTH + 1;
    localparam int DEN_WIDTH   = ROOT_WIDTH + 1;
    localparam int NUM_WIDTH   = COMP_WIDTH + RADIUS_WIDTH + 2;
    localparam int QUO_WIDTH   = RADIUS_WIDTH;
    localparam int CHAIN_DEPTH = ROOT_STEPS + 1 + QUO_WIDTH;
    localparam int DATA_WIDTH  = NUM_COMPS * COMP_WIDTH;

    typedef logic [NUM_COMPS-1:0][COMP_WIDTH-1:0] comp_vec_t;
    typedef logic [NUM_COMPS-1:0][NUM_WIDTH-1:0]  num_vec_t;
    typedef logic [NUM_COMPS-1:0][QUO_WIDTH-1:0]  quo_vec_t;

    typedef struct packed {
        comp_vec_t                comp;
        logic [RADIUS_WIDTH-1:0]  radius;
        logic                     bypass;
    } side_t;

    function automatic logic [COMP_WIDTH-1:0] comp_mag(input logic [COMP_WIDTH-1:0] c);
        logic [COMP_WIDTH-1:0] m;
        m = c[COMP_WIDTH-1] ? (~c + COMP_WIDTH'(1)) : c;
        return m;
    endfunction

endpackage

### rtl/l2bp_sqrt.sv
// ----------------------------------------------------------------------------
// l2bp_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module l2bp_sqrt
    import l2bp_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [NORM_WIDTH-1:0] norm,
    output logic [ROOT_WIDTH-1:0] root
);

    logic [SQRT_WIDTH-1:0] rem_reg [ROOT_STEPS];
    logic [SQRT_WIDTH-1:0] res_reg [ROOT_STEPS];

    genvar j;
    generate
        for (j = 0; j < ROOT_STEPS; j++) begin : g_step
            localparam logic [SQRT_WIDTH-1:0] STEP_BIT =
                SQRT_WIDTH'(1) << (2 * (ROOT_STEPS - 1 - j));
            logic [SQRT_WIDTH-1:0] rem_in;
            logic [SQRT_WIDTH-1:0] res_in;
            logic [SQRT_WIDTH-1:0] trial;
            logic [SQRT_WIDTH-1:0] rem_next;
            logic [SQRT_WIDTH-1:0] res_next;

            if (j == 0) begin : g_first
                assign rem_in = SQRT_WIDTH'(norm);
                assign res_in = '0;
            end else begin : g_rest
                assign rem_in = rem_reg[j-1];
                assign res_in = res_reg[j-1];
            end

            always_comb
            begin
                trial = res_in + STEP_BIT;
                if (rem_in >= trial)
                begin
                    rem_next = rem_in - trial;
                    res_next = (res_in >> 1) + STEP_BIT;
                end
                else
                begin
                    rem_next = rem_in;
                    res_next = res_in >> 1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= rem_next;
                    res_reg[j] <= res_next;
                end
            end
        end
    endgenerate

    assign root = res_reg[ROOT_STEPS-1][ROOT_WIDTH-1:0];

endmodule

### rtl/l2bp_div.sv
// ----------------------------------------------------------------------------
// l2bp_div
// Four-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module l2bp_div
    import l2bp_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  num_vec_t             num,
    input  logic [DEN_WIDTH-1:0] den,
    output quo_vec_t             quo
);

    num_vec_t             rem_reg [QUO_WIDTH];
    quo_vec_t             quo_reg [QUO_WIDTH];
    logic [DEN_WIDTH-1:0] den_reg [QUO_WIDTH];

    genvar s, k;
    generate
        for (s = 0; s < QUO_WIDTH; s++) begin : g_stage
            num_vec_t             rem_in;
            quo_vec_t             quo_in;
            logic [DEN_WIDTH-1:0] den_in;
            logic [NUM_WIDTH-1:0] dsh;
            num_vec_t             rem_next;
            quo_vec_t             quo_next;

            if (s == 0) begin : g_first
                assign rem_in = num;
                assign quo_in = '0;
                assign den_in = den;
            end else begin : g_rest
                assign rem_in = rem_reg[s-1];
                assign quo_in = quo_reg[s-1];
                assign den_in = den_reg[s-1];
            end

            assign dsh = NUM_WIDTH'(den_in) << (QUO_WIDTH - 1 - s);

            for (k = 0; k < NUM_COMPS; k++) begin : g_lane
                always_comb
                begin
                    if (rem_in[k] >= dsh)
                    begin
                        rem_next[k] = rem_in[k] - dsh;
                        quo_next[k] = {quo_in[k][QUO_WIDTH-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[k] = rem_in[k];
                        quo_next[k] = {quo_in[k][QUO_WIDTH-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next;
                    quo_reg[s] <= quo_next;
                    den_reg[s] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QUO_WIDTH-1];

endmodule

### rtl/l2_ball_projection_4vec_top.sv
// Projects each four-component vector onto the Euclidean ball of the programmed radius:
// vectors with squared norm below radius squared (and the zero vector) pass unchanged,
// all others are scaled by radius / floor(sqrt(norm)), rounded to nearest and saturated.
// One transaction is accepted per cycle while the output side takes results; each result passes
// through the 17-stage square root pipeline and the 16-stage divider that follows it. A stall
// on the output freezes the whole pipeline in place.
// ----------------------------------------------------------------------------
// l2_ball_projection_4vec_top
// Ball projection of Q3.12 four-vectors with a stream interface.
// ----------------------------------------------------------------------------
module l2_ball_projection_4vec_top
    import l2bp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [RADIUS_WIDTH-1:0] cfg_wr_data,     // radius
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [DATA_WIDTH-1:0]   s_axis_tdata,    // comp_0, comp_1, comp_2, comp_3
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [DATA_WIDTH-1:0]   m_axis_tdata     // out_0, out_1, out_2, out_3
);

`include "l2_ball_projection_4vec_top_assert.svh"

    logic                    en;
    logic [RADIUS_WIDTH-1:0] radius_reg;

    logic                    s1_valid_reg;
    comp_vec_t               s1_comp_reg;
    logic [SQ_WIDTH-1:0]     s1_sq_reg [NUM_COMPS];
    logic [R2_WIDTH-1:0]     s1_r2_reg;
    logic [RADIUS_WIDTH-1:0] s1_radius_reg;

    logic                    s2_valid_reg;
    logic [NORM_WIDTH-1:0]   s2_norm_reg;
    side_t                   s2_side_reg;
    logic [NORM_WIDTH-1:0]   s2_norm_next;

    logic                    valid_reg [CHAIN_DEPTH];
    side_t                   side_reg  [CHAIN_DEPTH];

    logic [ROOT_WIDTH-1:0]   root;
    num_vec_t                num_reg;
    logic [DEN_WIDTH-1:0]    den_reg;
    quo_vec_t                quo;

    logic                    out_valid_reg;
    comp_vec_t               out_data_reg;
    comp_vec_t               out_data_next;

    logic                    root_check;
    logic                    out_check;
    logic [RADIUS_WIDTH-1:0] out_radius;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_wr_en)
        begin
            radius_reg <= cfg_wr_data;
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHAIN_DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            s1_valid_reg  <= s_axis_tvalid;
            s2_valid_reg  <= s1_valid_reg;
            valid_reg[0]  <= s2_valid_reg;
            for (int i = 1; i < CHAIN_DEPTH; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
            out_valid_reg <= valid_reg[CHAIN_DEPTH-1];
        end
    end

    // squares and radius squared
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_comp_reg   <= s_axis_tdata;
            s1_radius_reg <= radius_reg;
            s1_r2_reg     <= R2_WIDTH'(radius_reg) * R2_WIDTH'(radius_reg);
            for (int k = 0; k < NUM_COMPS; k++)
            begin
                s1_sq_reg[k] <= SQ_WIDTH'(comp_mag(s_axis_tdata[k*COMP_WIDTH +: COMP_WIDTH]))
                              * SQ_WIDTH'(comp_mag(s_axis_tdata[k*COMP_WIDTH +: COMP_WIDTH]));
            end
        end
    end

    // norm and pass-through decision
    always_comb
    begin
        s2_norm_next = '0;
        for (int k = 0; k < NUM_COMPS; k++)
        begin
            s2_norm_next = s2_norm_next + NORM_WIDTH'(s1_sq_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_norm_reg        <= s2_norm_next;
            s2_side_reg.comp   <= s1_comp_reg;
            s2_side_reg.radius <= s1_radius_reg;
            s2_side_reg.bypass <= (s2_norm_next == '0)
                               || (s2_norm_next < NORM_WIDTH'(s1_r2_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= s2_side_reg;
            for (int i = 1; i < CHAIN_DEPTH; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    l2bp_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .norm (s2_norm_reg),
        .root (root)
    );

    // numerators 2*|c|*radius + root, divisor 2*root
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= {root, 1'b0};
            for (int k = 0; k < NUM_COMPS; k++)
            begin
                num_reg[k] <= ((NUM_WIDTH'(comp_mag(side_reg[ROOT_STEPS-1].comp[k]))
                               * NUM_WIDTH'(side_reg[ROOT_STEPS-1].radius)) << 1)
                            + NUM_WIDTH'(root);
            end
        end
    end

    l2bp_div u_div (
        .clk (clk),
        .en  (en),
        .num (num_reg),
        .den (den_reg),
        .quo (quo)
    );

    // sign, saturate, select
    always_comb
    begin
        for (int k = 0; k < NUM_COMPS; k++)
        begin
            if (side_reg[CHAIN_DEPTH-1].bypass)
            begin
                out_data_next[k] = side_reg[CHAIN_DEPTH-1].comp[k];
            end
            else if (side_reg[CHAIN_DEPTH-1].comp[k][COMP_WIDTH-1])
            begin
                if (quo[k] >= QUO_WIDTH'(1) << (COMP_WIDTH - 1))
                begin
                    out_data_next[k] = {1'b1, {(COMP_WIDTH-1){1'b0}}};
                end
                else
                begin
                    out_data_next[k] = ~quo[k][COMP_WIDTH-1:0] + COMP_WIDTH'(1);
                end
            end
            else
            begin
                if (quo[k] >= QUO_WIDTH'(1) << (COMP_WIDTH - 1))
                begin
                    out_data_next[k] = {1'b0, {(COMP_WIDTH-1){1'b1}}};
                end
                else
                begin
                    out_data_next[k] = quo[k][COMP_WIDTH-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign root_check = valid_reg[ROOT_STEPS-1] && !side_reg[ROOT_STEPS-1].bypass;
    assign out_check  = valid_reg[CHAIN_DEPTH-1] && !side_reg[CHAIN_DEPTH-1].bypass;
    assign out_radius = side_reg[CHAIN_DEPTH-1].radius;

    `L2BP_ASSERT_IMP(a_root_nonzero, root_check, root != '0)
    `L2BP_ASSERT_IMP(a_quo_bounded, out_check, quo[0] <= out_radius && quo[3] <= out_radius)
    `L2BP_ASSERT_IMP(a_zero_radius, out_check && out_radius == '0, quo == '0)
    `L2BP_ASSERT_NXT(a_stall_freeze, !en, $stable(valid_reg[CHAIN_DEPTH-1]) && $stable(s2_valid_reg))

endmodule
